// ===== rtl/bsct_pkg.sv =====
package bsct_pkg;

    // Timer mode, one-hot
    typedef enum logic [3:0] {
        MODE_SET = 4'b0001,
        MODE_CNT = 4'b0010,
        MODE_CLR = 4'b0100,
        MODE_FIN = 4'b1000
    } t_mode;

    // Mode codes as reported on the result channel
    localparam logic [1:0] MODE_CODE_SET = 2'd0;
    localparam logic [1:0] MODE_CODE_CNT = 2'd1;
    localparam logic [1:0] MODE_CODE_CLR = 2'd2;
    localparam logic [1:0] MODE_CODE_FIN = 2'd3;

    // Configuration register indexes
    localparam logic REG_CLEAR_HOLD = 1'b0;
    localparam logic REG_ACCEL_HOLD = 1'b1;

    // Request kinds
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [6:0] TIME_WRAP     = 7'd60;
    localparam logic [5:0] TIME_MAX      = 6'd59;
    localparam logic [5:0] FAST_STEP     = 6'd5;
    localparam logic [5:0] SLOW_STEP     = 6'd1;
    localparam logic [3:0] HELD_MAX      = 4'd15;
    localparam logic [3:0] CFG_RESET     = 4'd3;
    localparam int         SETTLE_PASSES = 8;

    typedef struct packed {
        t_mode      mode;
        logic       entered;
        logic [2:0] btn;
        logic       clr_before;
        logic [5:0] min_cnt;
        logic [5:0] sec_cnt;
        logic       min_fast;
        logic       sec_fast;
        logic [3:0] min_held;
        logic [3:0] sec_held;
        logic [3:0] clr_held;
        logic [1:0] rep;
        logic       counting;
        logic       done;
        logic       tick_en;
        logic       led;
    } t_state;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] minutes_out;
        logic [5:0] seconds_out;
        logic       led_on;
        logic       running;
    } t_result;

    // Add with wrap to zero at sixty
    function automatic logic [5:0] add_wrap(input logic [5:0] v, input logic [5:0] step);
        logic [6:0] sum;
        sum = {1'b0, v} + {1'b0, step};
        return (sum >= TIME_WRAP) ? 6'd0 : sum[5:0];
    endfunction

    // True when v is a multiple of five (v below 64)
    function automatic logic is_mult5(input logic [5:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 13; k++) begin
            if (v == 6'(5 * k)) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            MODE_SET: c = MODE_CODE_SET;
            MODE_CNT: c = MODE_CODE_CNT;
            MODE_CLR: c = MODE_CODE_CLR;
            MODE_FIN: c = MODE_CODE_FIN;
            default:  c = MODE_CODE_SET;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/bsct_in_if.sv =====
interface bsct_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [2:0] buttons;

    modport source (output valid, output action, output buttons, input ready);
    modport sink   (input valid, input action, input buttons, output ready);
endinterface

// ===== rtl/bsct_out_if.sv =====
interface bsct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [5:0] minutes_out;
    logic [5:0] seconds_out;
    logic       led_on;
    logic       running;

    modport source (output valid, output mode, output minutes_out, output seconds_out,
                    output led_on, output running, input ready);
    modport sink   (input valid, input mode, input minutes_out, input seconds_out,
                    input led_on, input running, output ready);
endinterface

// ===== rtl/bsct_update.sv =====
module bsct_update (
    input  bsct_pkg::t_state  i_state,
    input  logic              i_action,
    input  logic [2:0]        i_buttons,
    input  logic [3:0]        i_clear_hold,
    input  logic [3:0]        i_accel_hold,
    output bsct_pkg::t_state  o_state,
    output bsct_pkg::t_result o_result
);
    import bsct_pkg::*;

    always_comb begin
        t_state     s;
        logic       b0;
        logic       b1;
        logic       b2;
        logic [3:0] lim;
        logic       from_set;
        logic       stop;

        s = i_state;

        // Request phase: button sample or one-second tick
        if (i_action == ACT_SAMPLE) begin
            s.clr_before = s.btn[2];
            s.btn        = i_buttons;
        end else if (s.tick_en) begin
            if (s.mode == MODE_SET) begin
                if (s.btn[2]) s.clr_held = s.clr_held + 4'd1;
                if (s.rep[0] && s.btn[0]) begin
                    s.min_cnt = add_wrap(s.min_cnt, s.min_fast ? FAST_STEP : SLOW_STEP);
                    if (s.min_held != HELD_MAX) s.min_held = s.min_held + 4'd1;
                    if (!s.min_fast && s.min_held >= i_accel_hold && is_mult5(s.min_cnt))
                        s.min_fast = 1'b1;
                end
                if (s.rep[1] && s.btn[1]) begin
                    s.sec_cnt = add_wrap(s.sec_cnt, s.sec_fast ? FAST_STEP : SLOW_STEP);
                    if (s.sec_held != HELD_MAX) s.sec_held = s.sec_held + 4'd1;
                    if (!s.sec_fast && s.sec_held >= i_accel_hold && is_mult5(s.sec_cnt))
                        s.sec_fast = 1'b1;
                end
            end else if (s.mode == MODE_CNT) begin
                if (s.btn[2]) s.clr_held = s.clr_held + 4'd1;
                if (s.counting) begin
                    s.led = ~s.led;
                    if (s.sec_cnt == 6'd0) begin
                        if (s.min_cnt == 6'd0) begin
                            s.done = 1'b1;
                        end else begin
                            s.min_cnt = s.min_cnt - 6'd1;
                            s.sec_cnt = TIME_MAX;
                        end
                    end else begin
                        s.sec_cnt = s.sec_cnt - 6'd1;
                    end
                end
            end
        end

        b0       = s.btn[0];
        b1       = s.btn[1];
        b2       = s.btn[2];
        lim      = (i_clear_hold == 4'd0) ? 4'd1 : i_clear_hold;
        from_set = 1'b0;
        stop     = 1'b0;

        // Mode settling, a bounded number of transitions
        for (int p = 0; p < SETTLE_PASSES; p++) begin
            if (!stop) begin
                case (s.mode)
                    MODE_SET: begin
                        if (!b2 && s.clr_before) begin
                            s.mode = MODE_CNT; s.entered = 1'b0; s.tick_en = 1'b0;
                            from_set = 1'b1;
                        end else if (s.clr_held == lim) begin
                            s.mode = MODE_CLR; s.tick_en = 1'b0; s.clr_held = 4'd0;
                            s.entered = 1'b0; s.led = 1'b0;
                        end else begin
                            s.entered = 1'b1;
                            if (b0 || b1) begin
                                s.tick_en = 1'b1;
                                if (b0 && !s.rep[0]) begin
                                    s.min_fast = 1'b0; s.min_held = 4'd0; s.rep[0] = 1'b1;
                                    s.min_cnt  = add_wrap(s.min_cnt, SLOW_STEP);
                                end else if (!b0) begin
                                    s.rep[0] = 1'b0;
                                end
                                if (b1 && !s.rep[1]) begin
                                    s.sec_fast = 1'b0; s.sec_held = 4'd0; s.rep[1] = 1'b1;
                                    s.sec_cnt  = add_wrap(s.sec_cnt, SLOW_STEP);
                                end else if (!b1) begin
                                    s.rep[1] = 1'b0;
                                end
                            end else begin
                                s.tick_en = b2;
                                s.rep     = 2'b00;
                            end
                            stop = 1'b1;
                        end
                    end
                    MODE_CLR: begin
                        s.min_cnt = 6'd0;
                        s.sec_cnt = 6'd0;
                        if (b0 || b1) begin
                            s.mode = MODE_SET; s.entered = 1'b0;
                        end else begin
                            stop = 1'b1;
                        end
                    end
                    MODE_FIN: begin
                        if (!s.entered) begin
                            s.entered = 1'b1; s.led = 1'b1;
                        end
                        if (b0 || b1) begin
                            s.mode = MODE_SET; s.entered = 1'b0; s.led = 1'b0;
                        end else begin
                            stop = 1'b1;
                        end
                    end
                    MODE_CNT: begin
                        if (s.clr_held == lim) begin
                            s.mode = MODE_CLR; s.tick_en = 1'b0; s.counting = 1'b0;
                            s.clr_held = 4'd0; s.entered = 1'b0; s.led = 1'b0;
                        end else if (!from_set && !s.counting && (b0 || b1)) begin
                            s.mode = MODE_SET; s.tick_en = 1'b0; s.counting = 1'b0;
                            s.clr_held = 4'd0; s.entered = 1'b0; s.led = 1'b0;
                        end else if (s.done) begin
                            s.mode = MODE_FIN; s.entered = 1'b0; s.done = 1'b0;
                            s.tick_en = 1'b0;
                        end else begin
                            if (!s.entered) begin
                                s.entered = 1'b1; s.counting = 1'b0; s.tick_en = 1'b1;
                            end
                            // start/pause toggles on release of button 2
                            if (!b2 && s.clr_before) begin
                                s.counting   = ~s.counting;
                                s.led        = 1'b0;
                                s.clr_held   = 4'd0;
                                s.clr_before = 1'b0;
                            end
                            stop = 1'b1;
                        end
                    end
                    default: stop = 1'b1;
                endcase
            end
        end

        o_state              = s;
        o_result.mode        = mode_code(s.mode);
        o_result.minutes_out = s.min_cnt;
        o_result.seconds_out = s.sec_cnt;
        o_result.led_on      = s.led;
        o_result.running     = (s.mode == MODE_CNT) && s.counting;
    end

endmodule

// ===== rtl/button_set_countdown_timer_core.sv =====
// Minutes:seconds countdown timer set by three buttons.
// The result is registered at the edge that accepts the request.
// Throughput: one request per cycle; the single update path from the state
// register to the result register sets it; a full, unread result register stalls input.
// Reset (synchronous, active low) returns to SET at 00:00 with both config registers at 3.
module button_set_countdown_timer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    bsct_in_if.sink    i_in,
    bsct_out_if.source o_out
);
    import bsct_pkg::*;

    logic [3:0] r_clear_hold;
    logic [3:0] r_accel_hold;
    t_state     r_state;
    t_state     n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       accept;

    // Request accepted whenever the result register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    bsct_update u_update (
        .i_state      (r_state),
        .i_action     (i_in.action),
        .i_buttons    (i_in.buttons),
        .i_clear_hold (r_clear_hold),
        .i_accel_hold (r_accel_hold),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_hold <= CFG_RESET;
            r_accel_hold <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLEAR_HOLD: r_clear_hold <= i_cfg_data;
                REG_ACCEL_HOLD: r_accel_hold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_SET, default: '0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.mode        = r_result.mode;
    assign o_out.minutes_out = r_result.minutes_out;
    assign o_out.seconds_out = r_result.seconds_out;
    assign o_out.led_on      = r_result.led_on;
    assign o_out.running     = r_result.running;

endmodule
